// File: rtl/ttim_pkg.sv
// Shared constants and types for the tensor transpose index map.
package ttim_pkg;

  localparam int unsigned MAX_RANK   = 4;
  localparam int unsigned INDEX_BITS = 32;
  localparam int unsigned EXT_REGS   = 4;
  localparam int unsigned DEST_W     = 32;
  localparam int unsigned EXT_W      = 16;
  localparam int unsigned SRC_W      = 64;
  localparam int unsigned STRIDE_W   = 48;
  localparam int unsigned NUM_DIV    = EXT_REGS - 1;
  localparam int unsigned DIV_STEPS  = DEST_W;
  localparam int unsigned NUM_STAGES = NUM_DIV * DIV_STEPS;

  localparam logic [2:0] CFG_RANK        = 3'd0;
  localparam logic [2:0] CFG_EXTENT_0    = 3'd1;
  localparam logic [2:0] CFG_EXTENT_1    = 3'd2;
  localparam logic [2:0] CFG_EXTENT_2    = 3'd3;
  localparam logic [2:0] CFG_EXTENT_3    = 3'd4;
  localparam logic [2:0] CFG_SWAP_FIRST  = 3'd5;
  localparam logic [2:0] CFG_SWAP_SECOND = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CFG   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [DEST_W-1:0]           dest;
    logic [DEST_W-1:0]           num;
    logic [EXT_W-1:0]            rem;
    logic [NUM_DIV:1][EXT_W-1:0] coord;
  } ttim_stage_t;

endpackage

// File: rtl/tensor_transpose_index_map_top.sv
// Throughput: one word per cycle unless the output stalls; the bit-serial divider chain
// of 96 stages (three mixed-radix digits of 32 quotient bits) sets the depth, with one
// multiply stage, one add stage and the output register behind it.
// Reset clears the pipeline valid bits and loads the configuration reset values.
// Top level of the tensor transpose index map.
module tensor_transpose_index_map_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] dest_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] source_index_o,
  output logic [1:0]  status_o
);
  import ttim_pkg::*;

  logic [2:0]       rank_q, swap_first_q, swap_second_q;
  logic [EXT_W-1:0] ext_q [EXT_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q        <= 3'd2;
      swap_first_q  <= 3'd0;
      swap_second_q <= 3'd1;
      for (int i = 0; i < EXT_REGS; i++) begin
        ext_q[i] <= EXT_W'(1);
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANK:        rank_q        <= cfg_data_i[2:0];
        CFG_EXTENT_0:    ext_q[0]      <= cfg_data_i;
        CFG_EXTENT_1:    ext_q[1]      <= cfg_data_i;
        CFG_EXTENT_2:    ext_q[2]      <= cfg_data_i;
        CFG_EXTENT_3:    ext_q[3]      <= cfg_data_i;
        CFG_SWAP_FIRST:  swap_first_q  <= cfg_data_i[2:0];
        CFG_SWAP_SECOND: swap_second_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Configuration is normalized to four dimensions by padding unit extents on the outside.
  logic [4:0]       d0_s, d1_s;
  logic             cfg_err_d, id_d;
  logic [1:0]       off, pa, pb;
  logic [EXT_W-1:0] pe_d [EXT_REGS];
  logic [EXT_W-1:0] sw_d [EXT_REGS];
  logic [1:0]       from_d [EXT_REGS];

  always_comb begin
    d0_s = {{2{swap_first_q[2]}}, swap_first_q}
         + (swap_first_q[2] ? {2'b00, rank_q} : 5'd0);
    d1_s = {{2{swap_second_q[2]}}, swap_second_q}
         + (swap_second_q[2] ? {2'b00, rank_q} : 5'd0);
    cfg_err_d = (rank_q == 3'd0) || (32'(rank_q) > MAX_RANK) || (32'(rank_q) > EXT_REGS)
             || d0_s[4] || (d0_s >= {2'b00, rank_q})
             || d1_s[4] || (d1_s >= {2'b00, rank_q});
    off = 2'(3'd4 - rank_q);
    pa  = d0_s[1:0] + off;
    pb  = d1_s[1:0] + off;
    id_d = (pa == pb);
    for (int p = 0; p < EXT_REGS; p++) begin
      pe_d[p] = (2'(p) >= off) ? ext_q[2'(p) - off] : EXT_W'(1);
    end
    for (int p = 0; p < EXT_REGS; p++) begin
      if (2'(p) == pa) begin
        from_d[p] = pb;
      end else if (2'(p) == pb) begin
        from_d[p] = pa;
      end else begin
        from_d[p] = 2'(p);
      end
      sw_d[p] = pe_d[from_d[p]];
    end
  end

  logic             cfg_err_q, id_q;
  logic [EXT_W-1:0] pe_q [EXT_REGS];
  logic [EXT_W-1:0] sw_q [EXT_REGS];
  logic [1:0]       from_q [EXT_REGS];
  logic [31:0]      p23_q;
  logic [47:0]      p123_q;
  logic [SRC_W-1:0] count_q;
  logic [STRIDE_W-1:0] mstr_q [EXT_REGS];
  logic [STRIDE_W-1:0] stride_c [EXT_REGS];

  always_comb begin
    stride_c[3] = STRIDE_W'(1);
    stride_c[2] = STRIDE_W'(pe_q[3]);
    stride_c[1] = STRIDE_W'(p23_q);
    stride_c[0] = p123_q;
  end

  always_ff @(posedge clk_i) begin
    cfg_err_q <= cfg_err_d;
    id_q      <= id_d;
    for (int p = 0; p < EXT_REGS; p++) begin
      pe_q[p]   <= pe_d[p];
      sw_q[p]   <= sw_d[p];
      from_q[p] <= from_d[p];
      mstr_q[p] <= stride_c[from_q[p]];
    end
    p23_q   <= 32'(pe_q[2]) * 32'(pe_q[3]);
    p123_q  <= 48'(pe_q[1]) * 48'(p23_q);
    count_q <= 64'(pe_q[0]) * 64'(p123_q);
  end

  // Bit-serial division chain: one quotient bit per stage, innermost digit first.
  logic        en;
  logic        vld_q [NUM_STAGES+1];
  ttim_stage_t st_q [NUM_STAGES+1];
  ttim_stage_t st_d [NUM_STAGES+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    logic [EXT_W:0]   rem_n;
    logic [EXT_W-1:0] dvs;
    logic             ge;
    st_d[0].dest  = dest_index_i;
    st_d[0].num   = dest_index_i;
    st_d[0].rem   = '0;
    st_d[0].coord = '0;
    for (int k = 0; k < NUM_STAGES; k++) begin
      dvs   = sw_q[EXT_REGS - 1 - k / DIV_STEPS];
      rem_n = {st_q[k].rem, st_q[k].num[DEST_W-1]};
      ge    = rem_n >= {1'b0, dvs};
      st_d[k+1]       = st_q[k];
      st_d[k+1].num   = {st_q[k].num[DEST_W-2:0], ge};
      st_d[k+1].rem   = ge ? EXT_W'(rem_n - {1'b0, dvs}) : rem_n[EXT_W-1:0];
      if ((k % DIV_STEPS) == DIV_STEPS - 1) begin
        st_d[k+1].coord[NUM_DIV - k / DIV_STEPS] = st_d[k+1].rem;
        st_d[k+1].rem = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NUM_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 0; k < NUM_STAGES; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= NUM_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Scale, add and select.
  logic [EXT_W-1:0]  coord_c [EXT_REGS];
  logic              mul_vld_q, add_vld_q, out_vld_q;
  logic [SRC_W-1:0]  prod_q [EXT_REGS];
  logic [SRC_W-1:0]  sum_a_q, sum_b_q, src_c;
  logic [DEST_W-1:0] mul_dest_q, add_dest_q;
  logic              mul_bad_q, add_bad_q;
  logic [31:0]       out_src_q;
  logic [1:0]        out_st_q;

  always_comb begin
    coord_c[0] = st_q[NUM_STAGES].num[EXT_W-1:0];
    for (int p = 1; p < EXT_REGS; p++) begin
      coord_c[p] = st_q[NUM_STAGES].coord[p];
    end
    src_c = sum_a_q + sum_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      add_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= vld_q[NUM_STAGES];
      add_vld_q <= mul_vld_q;
      out_vld_q <= add_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < EXT_REGS; p++) begin
        prod_q[p] <= 64'(coord_c[p]) * 64'(mstr_q[p]);
      end
      mul_dest_q <= st_q[NUM_STAGES].dest;
      mul_bad_q  <= (count_q <= 64'(st_q[NUM_STAGES].dest))
                 || ((64'(st_q[NUM_STAGES].dest) >> INDEX_BITS) != 64'd0);
      sum_a_q    <= prod_q[0] + prod_q[1];
      sum_b_q    <= prod_q[2] + prod_q[3];
      add_dest_q <= mul_dest_q;
      add_bad_q  <= mul_bad_q;
      if (cfg_err_q) begin
        out_src_q <= '0;
        out_st_q  <= ST_CFG;
      end else if (add_bad_q) begin
        out_src_q <= '0;
        out_st_q  <= ST_RANGE;
      end else if (id_q) begin
        out_src_q <= add_dest_q;
        out_st_q  <= ST_OK;
      end else if ((src_c >> INDEX_BITS) != 64'd0) begin
        out_src_q <= '0;
        out_st_q  <= ST_RANGE;
      end else begin
        out_src_q <= src_c[31:0];
        out_st_q  <= ST_OK;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign source_index_o = out_src_q;
  assign status_o       = out_st_q;

`ifndef ASSERT_OFF
  a_status_zero_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> source_index_o == 32'd0)
    else $error("nonzero status with nonzero source index");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_CFG) || (status_o == ST_RANGE))
    else $error("undefined status code");
  a_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rank_q == 3'd0) |-> status_o == ST_CFG)
    else $error("rank zero not reported as config error");
`endif

endmodule
